// ----- hdl/brf_pkg.sv -----
// brf_pkg: shared widths, codes and state type of the byte ring fifo
// used by the top level, the checker and the bench; depends on nothing
`default_nettype none
package brf_pkg;

	localparam int RING_DEPTH_DEF = 1024;
	localparam int MAX_RUN_DEF    = 64;

	localparam int CNT_W  = 11;
	localparam int LEN_W  = 7;
	localparam int BYTE_W = 8;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam int IN_FIELDS_W  = BYTE_W + CNT_W + LEN_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = BYTE_W + STAT_W + CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_PEEK    = 2'd1,
		CMD_DISCARD = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_TOO_SMALL = 2'd1,
		STAT_NEED_MORE = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_PEEK = 1'b1
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/brf_ram.sv -----
// brf_ram: single-clock byte store, one write port and one registered read port
// read data holds while the read enable is low; no dependencies
`default_nettype none
module brf_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/byte_ring_fifo_peek_discard_top.sv -----
// byte_ring_fifo_peek_discard_top: byte ring fifo with whole-run writes, peek,
// discard and read; depends on brf_pkg and brf_ram
//
// channel  | direction | signals                         | content
// s_       | in        | tvalid tready tdata tuser       | command item
// m_       | out       | tvalid tready tdata tlast       | one result per transfer
// cfg_     | in        | valid ready data                | capacity_in_use
//
// write, discard and failed or empty peeks are taken one item per cycle while the output moves.
// a peek or read of n bytes holds the input while it makes one store read per byte,
// set by the single read port of the byte store; results pass the s1 and s2 stages.
// reset empties the ring and sets capacity to the store depth; no clearing pass.
// a stalled output stops the store reads and the input until it moves again.
`default_nettype none
module byte_ring_fifo_peek_discard_top #(
	parameter int RING_DEPTH = brf_pkg::RING_DEPTH_DEF,
	parameter int MAX_RUN    = brf_pkg::MAX_RUN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// data_byte [7:0], offset [18:8], length [25:19], zero pad
	input  wire logic [brf_pkg::IN_TDATA_W-1:0]   s_tdata,
	// command [1:0]
	input  wire logic [brf_pkg::CMD_W-1:0]        s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// data_out [7:0], status [9:8], fill_level [20:10], zero pad
	output logic      [brf_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// last
	output logic                                  m_tlast,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [brf_pkg::CNT_W-1:0]        cfg_data
);

	localparam int CNT_W   = brf_pkg::CNT_W;
	localparam int LEN_W   = brf_pkg::LEN_W;
	localparam int BYTE_W  = brf_pkg::BYTE_W;
	localparam int STAT_W  = brf_pkg::STAT_W;
	localparam int POS_W   = CNT_W + 1;
	localparam int ADDR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int CAP_MAX = (RING_DEPTH > CNT_MAX) ? CNT_MAX : RING_DEPTH;

	// input fields
	brf_pkg::cmd_t      cmd;
	logic [BYTE_W-1:0]  in_byte;
	logic [CNT_W-1:0]   in_off;
	logic [LEN_W-1:0]   in_len;

	// ring state
	logic [CNT_W-1:0]   cap_q, head_q, cnt_q, head_d, cnt_d;
	logic [LEN_W-1:0]   run_rem_q, run_rem_d;
	logic               run_rej_q, run_rej_d;
	brf_pkg::state_t    state_q, state_d;
	logic [CNT_W-1:0]   pos_q, pos_d;
	logic [LEN_W-1:0]   rem_q, rem_d;

	// result stages
	logic               v_s1, mem_s1, last_s1;
	brf_pkg::status_t   status_s1;
	logic [CNT_W-1:0]   fill_s1;
	logic               v_s2, last_s2;
	brf_pkg::status_t   status_s2;
	logic [BYTE_W-1:0]  data_s2;
	logic [CNT_W-1:0]   fill_s2;

	logic               adv, accept, cfg_fire, load_s1, mem_d, last_d;
	brf_pkg::status_t   status_d;
	logic               wr_en, rd_en;
	logic [BYTE_W-1:0]  rd_data;
	logic [POS_W-1:0]   cap_w, add_b, sum, sum_wrap, pk_next;
	logic [CNT_W-1:0]   free_cnt, off_eff, len_c, cfg_cap;

	assign cmd     = brf_pkg::cmd_t'(s_tuser);
	assign in_byte = s_tdata[BYTE_W-1:0];
	assign in_off  = s_tdata[BYTE_W+CNT_W-1:BYTE_W];
	assign in_len  = s_tdata[BYTE_W+CNT_W+LEN_W-1:BYTE_W+CNT_W];

	assign adv       = !v_s2 || m_tready;
	assign s_tready  = (state_q == brf_pkg::S_IDLE) && adv;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = (state_q == brf_pkg::S_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign len_c    = CNT_W'(in_len);
	assign off_eff  = (cmd == brf_pkg::CMD_READ) ? '0 : in_off;
	assign free_cnt = cap_q - cnt_q;
	assign cap_w    = POS_W'(cap_q);

	// one shared position adder: tail for writes, new head for discards and reads, start for peeks
	always_comb begin
		case (cmd)
			brf_pkg::CMD_WRITE: add_b = POS_W'(cnt_q);
			brf_pkg::CMD_PEEK:  add_b = POS_W'(off_eff);
			default:            add_b = POS_W'(len_c);
		endcase
	end
	assign sum      = POS_W'(head_q) + add_b;
	assign sum_wrap = (sum >= cap_w) ? sum - cap_w : sum;
	assign pk_next  = POS_W'(pos_q) + POS_W'(1);

	always_comb begin
		if (cfg_data == '0) begin
			cfg_cap = CNT_W'(1);
		end else if (32'(cfg_data) > RING_DEPTH) begin
			cfg_cap = CNT_W'(CAP_MAX);
		end else begin
			cfg_cap = cfg_data;
		end
	end

	always_comb begin
		head_d    = head_q;
		cnt_d     = cnt_q;
		run_rem_d = run_rem_q;
		run_rej_d = run_rej_q;
		state_d   = state_q;
		pos_d     = pos_q;
		rem_d     = rem_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		load_s1   = 1'b0;
		mem_d     = 1'b0;
		last_d    = 1'b1;
		status_d  = brf_pkg::STAT_OK;
		case (state_q)
			brf_pkg::S_IDLE: begin
				if (accept) begin
					load_s1 = 1'b1;
					case (cmd)
						brf_pkg::CMD_WRITE: begin
							if (run_rem_q == '0) begin
								if (in_len != '0) begin
									run_rem_d = in_len - LEN_W'(1);
									if (in_len > LEN_W'(MAX_RUN) || len_c > free_cnt) begin
										run_rej_d = 1'b1;
										status_d  = brf_pkg::STAT_TOO_SMALL;
									end else begin
										run_rej_d = 1'b0;
										if (cnt_q >= cap_q) begin
											status_d = brf_pkg::STAT_TOO_SMALL;
										end else begin
											wr_en = 1'b1;
											cnt_d = cnt_q + CNT_W'(1);
										end
									end
								end
							end else begin
								run_rem_d = run_rem_q - LEN_W'(1);
								if (run_rej_q || cnt_q >= cap_q) begin
									status_d = brf_pkg::STAT_TOO_SMALL;
								end else begin
									wr_en = 1'b1;
									cnt_d = cnt_q + CNT_W'(1);
								end
							end
						end
						brf_pkg::CMD_DISCARD: begin
							if (len_c > cnt_q) begin
								status_d = brf_pkg::STAT_NEED_MORE;
							end else begin
								cnt_d  = cnt_q - len_c;
								head_d = (cnt_q == len_c) ? '0 : CNT_W'(sum_wrap);
							end
						end
						default: begin
							if (off_eff > cnt_q || len_c > cnt_q - off_eff) begin
								status_d = brf_pkg::STAT_NEED_MORE;
							end else if (in_len > LEN_W'(MAX_RUN)) begin
								status_d = brf_pkg::STAT_TOO_SMALL;
							end else if (in_len != '0) begin
								load_s1 = 1'b0;
								state_d = brf_pkg::S_PEEK;
								rem_d   = in_len;
								if (cmd == brf_pkg::CMD_READ) begin
									pos_d  = head_q;
									cnt_d  = cnt_q - len_c;
									head_d = (cnt_q == len_c) ? '0 : CNT_W'(sum_wrap);
								end else begin
									pos_d = CNT_W'(sum_wrap);
								end
							end
						end
					endcase
				end
			end
			brf_pkg::S_PEEK: begin
				if (adv) begin
					load_s1 = 1'b1;
					rd_en   = 1'b1;
					mem_d   = 1'b1;
					last_d  = (rem_q == LEN_W'(1));
					rem_d   = rem_q - LEN_W'(1);
					pos_d   = (pk_next >= cap_w) ? '0 : CNT_W'(pk_next);
					if (rem_q == LEN_W'(1)) begin
						state_d = brf_pkg::S_IDLE;
					end
				end
			end
			default: state_d = brf_pkg::S_IDLE;
		endcase
	end

	brf_ram #(
		.DEPTH  (RING_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (BYTE_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ADDR_W'(sum_wrap)),
		.wr_data (in_byte),
		.rd_en   (rd_en),
		.rd_addr (ADDR_W'(pos_q)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CNT_W'(CAP_MAX);
			head_q    <= '0;
			cnt_q     <= '0;
			run_rem_q <= '0;
			run_rej_q <= 1'b0;
			state_q   <= brf_pkg::S_IDLE;
			pos_q     <= '0;
			rem_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			rem_q   <= rem_d;
			if (cfg_fire) begin
				cap_q     <= cfg_cap;
				head_q    <= '0;
				cnt_q     <= '0;
				run_rem_q <= '0;
				run_rej_q <= 1'b0;
			end else begin
				head_q    <= head_d;
				cnt_q     <= cnt_d;
				run_rem_q <= run_rem_d;
				run_rej_q <= run_rej_d;
			end
			if (adv) begin
				v_s1 <= load_s1;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (load_s1) begin
				mem_s1    <= mem_d;
				last_s1   <= last_d;
				status_s1 <= status_d;
				fill_s1   <= cnt_d;
			end
			data_s2   <= mem_s1 ? rd_data : '0;
			last_s2   <= last_s1;
			status_s2 <= status_s1;
			fill_s2   <= fill_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {{brf_pkg::OUT_PAD_W{1'b0}}, fill_s2, STAT_W'(status_s2), data_s2};

endmodule
`default_nettype wire

// ----- hdl/brf_checker.sv -----
// brf_checker: port-level checks on the byte ring fifo top level, with its bind
// depends on brf_pkg and byte_ring_fifo_peek_discard_top
`default_nettype none
module brf_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [brf_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input wire logic                             m_tlast,
	input wire logic                             cfg_ready
);

	localparam int ST_LO = brf_pkg::BYTE_W;
	localparam int ST_HI = brf_pkg::BYTE_W + brf_pkg::STAT_W - 1;

	logic [brf_pkg::STAT_W-1:0] st;
	assign st = m_tdata[ST_HI:ST_LO];

	// a stalled result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// an error result is always the only result of its item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != brf_pkg::STAT_OK |-> m_tlast)
		else $error("error result not marked last");

	// a data byte only travels with an ok status
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[brf_pkg::BYTE_W-1:0] != '0 |-> st == brf_pkg::STAT_OK)
		else $error("data byte on error result");

	// input is only taken between peek bursts, where the config port is open too
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> cfg_ready)
		else $error("input ready during peek burst");

endmodule

bind byte_ring_fifo_peek_discard_top brf_checker u_brf_checker (.*);
`default_nettype wire

// ----- test/byte_ring_fifo_peek_discard_top_tb.sv -----
// byte_ring_fifo_peek_discard_top_tb: self-checking bench for the byte ring fifo top,
// directed and random command streams checked against a cycle-free ring predictor
// depends on brf_pkg and byte_ring_fifo_peek_discard_top
`timescale 1ns / 1ps
module byte_ring_fifo_peek_discard_top_tb;

	localparam int unsigned DEPTH      = brf_pkg::RING_DEPTH_DEF;
	localparam int unsigned RUN_MAX    = brf_pkg::MAX_RUN_DEF;
	localparam int unsigned QUIET_LIMIT = 4000;

	localparam int BYTE_W      = brf_pkg::BYTE_W;
	localparam int CNT_W       = brf_pkg::CNT_W;
	localparam int LEN_W       = brf_pkg::LEN_W;
	localparam int CMD_W       = brf_pkg::CMD_W;
	localparam int STAT_W      = brf_pkg::STAT_W;
	localparam int IN_TDATA_W  = brf_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = brf_pkg::OUT_TDATA_W;

	typedef struct packed {
		brf_pkg::cmd_t     command;
		logic [BYTE_W-1:0] data_byte;
		logic [CNT_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
	} ring_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		brf_pkg::status_t  status;
		logic              last;
		logic [CNT_W-1:0]  fill_level;
	} ring_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CNT_W-1:0]       cfg_data = '0;

	byte_ring_fifo_peek_discard_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [BYTE_W-1:0] ring_bytes [DEPTH];
	int unsigned       ring_head = 0;
	int unsigned       ring_fill = 0;
	int unsigned       ring_cap = DEPTH;
	int unsigned       run_left = 0;
	bit                run_refused = 1'b0;

	ring_cmd_t   cmds_to_send [$];
	ring_reply_t ring_replies_due [$];
	ring_cmd_t   cmd_on_bus;

	// fill level, capacity and run state as seen while planning stimulus
	int unsigned gen_fill = 0;
	int unsigned gen_cap = DEPTH;
	int unsigned gen_run_left = 0;
	bit          gen_run_ok = 1'b0;
	int unsigned cmds_planned = 0;

	int unsigned      send_gap_pct = 0;
	int unsigned      recv_stall_pct = 0;
	bit               cfg_req = 1'b0;
	logic [CNT_W-1:0] cfg_value = '0;

	int unsigned mismatches = 0;
	int unsigned cmds_accepted = 0;
	int unsigned replies_checked = 0;
	int unsigned capacity_writes = 0;
	int unsigned quiet_cycles = 0;

	function automatic int unsigned ring_wrap(int unsigned p);
		return (p >= ring_cap) ? p - ring_cap : p;
	endfunction

	function automatic brf_pkg::status_t push_ring_byte(logic [BYTE_W-1:0] b);
		if (ring_fill >= ring_cap)
			return brf_pkg::STAT_TOO_SMALL;
		ring_bytes[ring_wrap(ring_head + ring_fill)] = b;
		ring_fill++;
		return brf_pkg::STAT_OK;
	endfunction

	function automatic brf_pkg::status_t drop_ring_bytes(int unsigned n);
		if (n > ring_fill)
			return brf_pkg::STAT_NEED_MORE;
		ring_head = ring_wrap(ring_head + n);
		ring_fill -= n;
		if (ring_fill == 0)
			ring_head = 0;
		return brf_pkg::STAT_OK;
	endfunction

	function automatic void set_ring_capacity(logic [CNT_W-1:0] v);
		int unsigned c;
		c = 32'(v);
		if (c == 0)
			c = 1;
		if (c > DEPTH)
			c = DEPTH;
		ring_cap = c;
		ring_head = 0;
		ring_fill = 0;
		run_left = 0;
		run_refused = 1'b0;
	endfunction

	function automatic void apply_ring_cmd(ring_cmd_t c);
		ring_reply_t replies [$];
		ring_reply_t r;
		int unsigned off;
		int unsigned len;
		int unsigned pos;
		int unsigned i;
		off = 32'(c.offset);
		len = 32'(c.length);
		r = '{data_out: '0, status: brf_pkg::STAT_OK, last: 1'b1, fill_level: '0};
		case (c.command)
			brf_pkg::CMD_WRITE: begin
				if (run_left == 0) begin
					if (len != 0) begin
						run_left = len - 1;
						run_refused = (len > RUN_MAX) || (len > ring_cap - ring_fill);
						r.status = run_refused ? brf_pkg::STAT_TOO_SMALL
							: push_ring_byte(c.data_byte);
					end
				end else begin
					run_left--;
					r.status = run_refused ? brf_pkg::STAT_TOO_SMALL
						: push_ring_byte(c.data_byte);
				end
				replies.push_back(r);
			end
			brf_pkg::CMD_DISCARD: begin
				r.status = drop_ring_bytes(len);
				replies.push_back(r);
			end
			default: begin
				if (c.command == brf_pkg::CMD_READ)
					off = 0;
				if (off > ring_fill || len > ring_fill - off)
					r.status = brf_pkg::STAT_NEED_MORE;
				else if (len > RUN_MAX)
					r.status = brf_pkg::STAT_TOO_SMALL;
				if (r.status != brf_pkg::STAT_OK || len == 0) begin
					replies.push_back(r);
				end else begin
					pos = ring_wrap(ring_head + off);
					for (i = 0; i < len; i++) begin
						r.data_out = ring_bytes[pos];
						r.last = (i + 1 == len);
						replies.push_back(r);
						pos = ring_wrap(pos + 1);
					end
					if (c.command == brf_pkg::CMD_READ)
						void'(drop_ring_bytes(len));
				end
			end
		endcase
		foreach (replies[k]) begin
			replies[k].fill_level = CNT_W'(ring_fill);
			ring_replies_due.push_back(replies[k]);
		end
	endfunction

	function automatic void queue_cmd(brf_pkg::cmd_t c, logic [BYTE_W-1:0] b,
			logic [CNT_W-1:0] off, logic [LEN_W-1:0] len);
		cmds_to_send.push_back('{command: c, data_byte: b, offset: off, length: len});
		cmds_planned++;
		case (c)
			brf_pkg::CMD_WRITE: begin
				if (gen_run_left != 0) begin
					gen_run_left--;
					if (gen_run_ok)
						gen_fill++;
				end else if (len != 0) begin
					gen_run_left = 32'(len) - 1;
					gen_run_ok = (32'(len) <= RUN_MAX) && (32'(len) <= gen_cap - gen_fill);
					if (gen_run_ok)
						gen_fill++;
				end
			end
			brf_pkg::CMD_DISCARD: if (32'(len) <= gen_fill) gen_fill -= 32'(len);
			brf_pkg::CMD_READ: if (32'(len) <= gen_fill && 32'(len) <= RUN_MAX)
				gen_fill -= 32'(len);
			default: ;
		endcase
	endfunction

	function automatic void queue_run(int unsigned len);
		int unsigned i;
		queue_cmd(brf_pkg::CMD_WRITE, BYTE_W'($urandom), CNT_W'($urandom), LEN_W'(len));
		for (i = 1; i < len; i++)
			queue_cmd(brf_pkg::CMD_WRITE, BYTE_W'($urandom), CNT_W'($urandom),
				LEN_W'($urandom));
	endfunction

	task automatic random_traffic(int unsigned n_items);
		int unsigned first;
		int unsigned pick;
		int unsigned room;
		int unsigned len;
		int unsigned off;
		int unsigned lmax;
		int unsigned sel;
		first = cmds_planned;
		while (cmds_planned - first < n_items || gen_run_left != 0) begin
			pick = $urandom_range(99);
			if (gen_run_left != 0 && pick < 80) begin
				queue_cmd(brf_pkg::CMD_WRITE, BYTE_W'($urandom), CNT_W'($urandom),
					LEN_W'($urandom));
			end else if (gen_run_left == 0 && pick < 40) begin
				room = gen_cap - gen_fill;
				pick = $urandom_range(99);
				if (pick < 4)
					len = 0;
				else if (pick < 6)
					len = $urandom_range(65, 70);
				else if (pick < 16 || room == 0)
					len = (room < RUN_MAX) ? room + 1 : 1;
				else
					len = $urandom_range(1, (room < 12) ? room : (pick < 30 ? RUN_MAX : 12));
				queue_cmd(brf_pkg::CMD_WRITE, BYTE_W'($urandom), CNT_W'($urandom),
					LEN_W'(len));
			end else if (pick < 90 || gen_run_left != 0) begin
				sel = $urandom_range(2);
				if (sel == 0 && gen_fill * 4 > gen_cap * 3)
					sel = 1;
				case (sel)
					0: begin
						off = $urandom_range(0, gen_fill);
						lmax = gen_fill - off;
						if (lmax > RUN_MAX)
							lmax = RUN_MAX;
						queue_cmd(brf_pkg::CMD_PEEK, BYTE_W'($urandom), CNT_W'(off),
							LEN_W'($urandom_range(0, lmax)));
					end
					1: begin
						lmax = (gen_fill > RUN_MAX) ? RUN_MAX : gen_fill;
						queue_cmd(brf_pkg::CMD_READ, BYTE_W'($urandom), CNT_W'($urandom),
							LEN_W'($urandom_range(0, lmax)));
					end
					default: begin
						lmax = (gen_fill > 127) ? 127 : gen_fill;
						queue_cmd(brf_pkg::CMD_DISCARD, BYTE_W'($urandom), CNT_W'($urandom),
							LEN_W'($urandom_range(0, lmax)));
					end
				endcase
			end else begin
				queue_cmd(brf_pkg::cmd_t'($urandom_range(1, 3)), BYTE_W'($urandom),
					CNT_W'($urandom), LEN_W'($urandom));
			end
		end
	endtask

	task automatic settle();
		while (cmds_to_send.size() != 0 || s_tvalid || ring_replies_due.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] v);
		settle();
		cfg_value = v;
		cfg_req = 1'b1;
		while (cfg_req)
			@(negedge clk);
		gen_cap = (v == 0) ? 1 : ((32'(v) > DEPTH) ? DEPTH : 32'(v));
		gen_fill = 0;
		gen_run_left = 0;
		gen_run_ok = 1'b0;
		capacity_writes++;
	endtask

	task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
		send_gap_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// command sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_ring_cmd(cmd_on_bus);
				cmds_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (cmds_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					cmd_on_bus = cmds_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= IN_TDATA_W'({cmd_on_bus.length, cmd_on_bus.offset,
						cmd_on_bus.data_byte});
					s_tuser <= cmd_on_bus.command;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// capacity register writer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				set_ring_capacity(cfg_data);
				cfg_req = 1'b0;
			end
			cfg_valid <= cfg_req;
			cfg_data <= cfg_value;
		end
	end

	// reply checker
	always @(posedge clk or negedge arst_n) begin
		ring_reply_t got;
		ring_reply_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.data_out = m_tdata[BYTE_W-1:0];
				got.status = brf_pkg::status_t'(m_tdata[BYTE_W +: STAT_W]);
				got.last = m_tlast;
				got.fill_level = m_tdata[BYTE_W+STAT_W +: CNT_W];
				if (ring_replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 100)
						$display("%0t: unexpected reply data %0d status %0d last %0d fill %0d",
							$time, got.data_out, got.status, got.last, got.fill_level);
				end else begin
					want = ring_replies_due.pop_front();
					replies_checked++;
					if (got.data_out !== want.data_out || got.status !== want.status ||
							got.last !== want.last || got.fill_level !== want.fill_level) begin
						mismatches++;
						if (mismatches <= 100)
							$display({"%0t: reply mismatch expected data %0d status %0d last %0d",
								" fill %0d, actual data %0d status %0d last %0d fill %0d"},
								$time, want.data_out, want.status, want.last, want.fill_level,
								got.data_out, got.status, got.last, got.fill_level);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty ring, default capacity, no idling
		set_idling(0, 0);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd0, 7'd0);
		queue_cmd(brf_pkg::CMD_READ, 8'hff, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_DISCARD, 8'h00, 11'd0, 7'd0);
		queue_cmd(brf_pkg::CMD_DISCARD, 8'h00, 11'd0, 7'd127);
		queue_cmd(brf_pkg::CMD_PEEK, 8'hff, 11'd2047, 7'd127);
		queue_cmd(brf_pkg::CMD_WRITE, 8'hff, 11'd0, 7'd0);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h00, 11'd0, 7'd4);
		queue_cmd(brf_pkg::CMD_WRITE, 8'hff, 11'd2047, 7'd127);
		queue_cmd(brf_pkg::CMD_WRITE, 8'ha5, 11'd2047, 7'd127);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h5a, 11'd0, 7'd0);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd1, 7'd2);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd4, 7'd0);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd5, 7'd0);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd0, 7'd5);
		queue_cmd(brf_pkg::CMD_READ, 8'h00, 11'd2047, 7'd2);
		// commands between the bytes of a run
		queue_cmd(brf_pkg::CMD_WRITE, 8'h11, 11'd0, 7'd3);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd0, 7'd3);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h22, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_DISCARD, 8'h00, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h33, 11'd0, 7'd64);
		queue_cmd(brf_pkg::CMD_READ, 8'h00, 11'd0, 7'd4);

		// zero capacity turns into a one-byte ring
		write_capacity(11'd0);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h7e, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h01, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h02, 11'd0, 7'd2);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h03, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_PEEK, 8'h00, 11'd1, 7'd0);
		queue_cmd(brf_pkg::CMD_READ, 8'h00, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_DISCARD, 8'h00, 11'd0, 7'd1);
		queue_cmd(brf_pkg::CMD_WRITE, 8'h81, 11'd0, 7'd1);

		// oversized capacity clamps to the store depth
		write_capacity(11'd2047);
		set_idling(50, 0);
		queue_run(65);
		queue_run(64);
		queue_run(8);
		queue_cmd(brf_pkg::CMD_PEEK, BYTE_W'($urandom), 11'd0, 7'd70);
		queue_cmd(brf_pkg::CMD_READ, BYTE_W'($urandom), 11'd0, 7'd72);
		random_traffic(12);

		write_capacity(11'd37);
		set_idling(0, 50);
		random_traffic(45);

		write_capacity(11'd100);
		set_idling(9, 9);
		random_traffic(45);

		write_capacity(11'd1);
		set_idling(0, 0);
		random_traffic(20);

		write_capacity(11'd1024);
		set_idling(9, 9);
		random_traffic(25);

		settle();
		repeat (10) @(negedge clk);
		$display("%0d commands sent, %0d replies checked, %0d capacity writes",
			cmds_accepted, replies_checked, capacity_writes);
		$display("ring sizes 1 to 1024 with wraparound, refused runs and sender/receiver stalls");
		if (mismatches == 0 && ring_replies_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d replies missing", mismatches, ring_replies_due.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/brf_pkg.sv
hdl/brf_ram.sv
hdl/byte_ring_fifo_peek_discard_top.sv
hdl/brf_checker.sv
test/byte_ring_fifo_peek_discard_top_tb.sv
